/* hw/rtl/fdw_pkg.sv */
// Package for the framebuffer dirty window update block.
// Geometry constants, mode codes, transaction and internal types. No dependencies.
`default_nettype none
package fdw_pkg;

    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int FRAME_BYTES = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int COL_W       = 7;
    localparam int PAGE_W      = 3;
    localparam int COUNT_W     = 11;

    typedef enum logic [1:0] {
        MODE_SET_PIXEL = 2'd0,
        MODE_CLEAR     = 2'd1,
        MODE_SCAN      = 2'd2,
        MODE_READ      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PIX,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pix_x;
        logic [7:0] pix_y;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]   win_col_first;
        logic [COL_W-1:0]   win_col_final;
        logic [PAGE_W-1:0]  win_page_first;
        logic [PAGE_W-1:0]  win_page_final;
        logic [COUNT_W-1:0] byte_count;
        logic               window_empty;
        logic [7:0]         data_byte;
        logic               data_valid;
        logic               last_byte;
    } t_out_item;

    // one compared byte position during a scan
    typedef struct packed {
        logic              vld;
        logic [COL_W-1:0]  col;
        logic [PAGE_W-1:0] page;
    } t_hit;

    // running bounding window
    typedef struct packed {
        logic              any;
        logic [COL_W-1:0]  c0;
        logic [COL_W-1:0]  c1;
        logic [PAGE_W-1:0] p0;
        logic [PAGE_W-1:0] p1;
    } t_win;

endpackage
`default_nettype wire

/* hw/rtl/fdw_ram.sv */
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module fdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/fdw_win.sv */
// Bounding window accumulator for the difference scan.
// Depends on fdw_pkg.
`default_nettype none
module fdw_win (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire fdw_pkg::t_hit i_hit,
    output fdw_pkg::t_win     o_win
);
    import fdw_pkg::*;

    t_win r_win;
    t_win n_win;

    always_comb begin
        n_win = r_win;
        if (i_start) begin
            n_win.any = 1'b0;
            n_win.c0  = COL_W'(COLUMNS - 1);
            n_win.c1  = '0;
            n_win.p0  = PAGE_W'(PAGES - 1);
            n_win.p1  = '0;
        end else if (i_hit.vld) begin
            n_win.any = 1'b1;
            if (i_hit.col < r_win.c0) begin
                n_win.c0 = i_hit.col;
            end
            if (i_hit.col > r_win.c1) begin
                n_win.c1 = i_hit.col;
            end
            if (i_hit.page < r_win.p0) begin
                n_win.p0 = i_hit.page;
            end
            if (i_hit.page > r_win.p1) begin
                n_win.p1 = i_hit.page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule
`default_nettype wire

/* hw/rtl/framebuffer_dirty_window_update.sv */
// Set pixel goes through ST_PIX, read byte through ST_READ (both answer from idle when off
// screen or with no bytes left); clear sweeps the frame, scan sweeps it then ST_DRAIN, ST_DONE.
// One result per transaction. Input stalls outside idle, so each transaction finishes before
// the next is taken; set pixel does a read-modify-write through the registered-read frame RAMs.
// Reset: both frames are zeroed by a sweep over all FRAME_BYTES (1024) addresses, stall held high.
// Top level; depends on fdw_pkg, fdw_ram and fdw_win.
`default_nettype none
module framebuffer_dirty_window_update (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fdw_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fdw_pkg::t_out_item      o_out_data
);
    import fdw_pkg::*;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]  r_cnt, n_cnt;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_idx, n_pend_idx;
    logic [ADDR_W-1:0]  r_pix_addr, n_pix_addr;
    logic [7:0]         r_pix_bit, n_pix_bit;
    logic [ADDR_W-1:0]  r_cursor, n_cursor;
    logic [COUNT_W-1:0] r_bytes_left, n_bytes_left;
    t_win               r_bounds, n_bounds;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               draw_we, shown_we;
    logic [ADDR_W-1:0]  draw_waddr, shown_waddr, draw_raddr, shown_raddr;
    logic [7:0]         draw_wdata, shown_wdata, draw_rdata, shown_rdata;

    logic               accept;
    logic               cnt_last;
    logic               onscreen;
    logic [ADDR_W-1:0]  pix_addr;
    t_mode              in_mode;
    logic               win_start;
    t_hit               hit;
    t_win               win;
    logic [COL_W:0]     win_w;
    logic [PAGE_W:0]    win_h;
    logic [COL_W+PAGE_W+1:0] win_area;

    assign o_in_stall = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;
    assign in_mode    = t_mode'(i_in_data.mode);
    assign cnt_last   = (r_cnt == ADDR_W'(FRAME_BYTES - 1));
    assign onscreen   = (32'(i_in_data.pix_x) < COLUMNS) && (32'(i_in_data.pix_y) < ROWS);
    assign pix_addr   = ADDR_W'(32'(i_in_data.pix_y >> 3) * COLUMNS + 32'(i_in_data.pix_x));

    assign win_start  = accept && (in_mode == MODE_SCAN);
    assign hit.vld    = r_pend && (draw_rdata != shown_rdata);
    assign hit.col    = COL_W'(r_pend_idx % COLUMNS);
    assign hit.page   = PAGE_W'(r_pend_idx / COLUMNS);

    assign win_w      = {1'b0, win.c1} - {1'b0, win.c0} + 1'b1;
    assign win_h      = {1'b0, win.p1} - {1'b0, win.p0} + 1'b1;
    assign win_area   = win_w * win_h;

    fdw_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (win_start),
        .i_hit   (hit),
        .o_win   (win)
    );

    fdw_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_draw_ram (
        .i_clk   (i_clk),
        .i_we    (draw_we),
        .i_waddr (draw_waddr),
        .i_wdata (draw_wdata),
        .i_raddr (draw_raddr),
        .o_rdata (draw_rdata)
    );

    fdw_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_shown_ram (
        .i_clk   (i_clk),
        .i_we    (shown_we),
        .i_waddr (shown_waddr),
        .i_wdata (shown_wdata),
        .i_raddr (shown_raddr),
        .o_rdata (shown_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_mode)
                        MODE_SET_PIXEL: n_state = onscreen ? ST_PIX : ST_IDLE;
                        MODE_CLEAR:     n_state = ST_CLEAR;
                        MODE_SCAN:      n_state = ST_SCAN;
                        MODE_READ:      n_state = (r_bytes_left != '0) ? ST_READ : ST_IDLE;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIX:   n_state = ST_IDLE;
            ST_CLEAR: begin
                if (cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            ST_READ:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory controls and datapath
    always_comb begin
        draw_we      = 1'b0;
        draw_waddr   = r_cnt;
        draw_wdata   = '0;
        draw_raddr   = r_cnt;
        shown_we     = 1'b0;
        shown_waddr  = r_cnt;
        shown_wdata  = '0;
        shown_raddr  = r_cursor;

        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_pend_idx   = r_cnt;
        n_pix_addr   = r_pix_addr;
        n_pix_bit    = r_pix_bit;
        n_cursor     = r_cursor;
        n_bytes_left = r_bytes_left;
        n_bounds     = r_bounds;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_INIT: begin
                draw_we  = 1'b1;
                shown_we = 1'b1;
                n_cnt    = cnt_last ? '0 : r_cnt + 1'b1;
            end
            ST_IDLE: begin
                draw_raddr = pix_addr;
                n_pix_addr = pix_addr;
                n_pix_bit  = 8'(1) << i_in_data.pix_y[2:0];
                if (accept) begin
                    n_out = '0;
                    // results that need no memory access go out right away
                    if ((in_mode == MODE_SET_PIXEL && !onscreen) ||
                        (in_mode == MODE_READ && r_bytes_left == '0)) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_PIX: begin
                draw_we     = 1'b1;
                draw_waddr  = r_pix_addr;
                draw_wdata  = draw_rdata | r_pix_bit;
                n_out       = '0;
                n_out_valid = 1'b1;
            end
            ST_CLEAR: begin
                draw_we = 1'b1;
                n_cnt   = cnt_last ? '0 : r_cnt + 1'b1;
                if (cnt_last) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                end
            end
            ST_SCAN: begin
                shown_raddr = r_cnt;
                // copy the byte compared this cycle, read one behind
                shown_we    = r_pend;
                shown_waddr = r_pend_idx;
                shown_wdata = draw_rdata;
                n_pend      = 1'b1;
                n_pend_idx  = r_cnt;
                n_cnt       = cnt_last ? '0 : r_cnt + 1'b1;
            end
            ST_DRAIN: begin
                shown_we    = r_pend;
                shown_waddr = r_pend_idx;
                shown_wdata = draw_rdata;
            end
            ST_DONE: begin
                n_out       = '0;
                n_out_valid = 1'b1;
                if (win.any) begin
                    n_bounds     = win;
                    n_bytes_left = COUNT_W'(win_area);
                    n_cursor     = ADDR_W'(32'(win.p0) * COLUMNS + 32'(win.c0));
                    n_out.win_col_first  = win.c0;
                    n_out.win_col_final  = win.c1;
                    n_out.win_page_first = win.p0;
                    n_out.win_page_final = win.p1;
                    n_out.byte_count     = COUNT_W'(win_area);
                end else begin
                    n_bounds     = '0;
                    n_bytes_left = '0;
                    n_cursor     = '0;
                    n_out.window_empty = 1'b1;
                end
            end
            ST_READ: begin
                n_out            = '0;
                n_out.data_byte  = shown_rdata;
                n_out.data_valid = 1'b1;
                n_out.last_byte  = (r_bytes_left == COUNT_W'(1));
                n_out_valid      = 1'b1;
                // end of a window row jumps to the first window column of the next page
                if (COL_W'(r_cursor % COLUMNS) >= r_bounds.c1) begin
                    n_cursor = ADDR_W'(32'(r_cursor) + COLUMNS
                                       - 32'(r_bounds.c1 - r_bounds.c0));
                end else begin
                    n_cursor = r_cursor + 1'b1;
                end
                n_bytes_left = r_bytes_left - 1'b1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_cursor     <= '0;
            r_bytes_left <= '0;
            r_bounds     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend       <= n_pend;
            r_cursor     <= n_cursor;
            r_bytes_left <= n_bytes_left;
            r_bounds     <= n_bounds;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_pix_addr <= n_pix_addr;
        r_pix_bit  <= n_pix_bit;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
